/* hw/rtl/glu_pkg.sv */
// ----------------------------------------------------------------------------
// glu_pkg
// Shared types and constants for the gcd/lcm unit: job record passed from
// the front end to the back end through the job queue, and queue status.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int unsigned OPND_W  = 32;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic FUNC_GCD = 1'b0;
  localparam logic FUNC_LCM = 1'b1;

  localparam logic [1:0] KIND_GCD = 2'd0;
  localparam logic [1:0] KIND_LCM = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic              neg;
    logic [OPND_W-1:0] mag_a;
    logic [OPND_W-1:0] mag_b;
  } glu_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } glu_qstat_t;

endpackage

/* hw/rtl/glu_front.sv */
// ----------------------------------------------------------------------------
// glu_front
// Input side: accepts beats, takes operand magnitudes and sign, and sorts
// each beat into a gcd job, an lcm job or an lcm error before queuing it.
// ----------------------------------------------------------------------------
module glu_front (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [63:0]              in_tdata,
  input  logic                     in_tuser,
  input  glu_pkg::glu_qstat_t      qstat,
  output logic                     push,
  output glu_pkg::glu_job_t        job
);

  logic [glu_pkg::OPND_W-1:0] opa;
  logic [glu_pkg::OPND_W-1:0] opb;
  logic [glu_pkg::OPND_W-1:0] mag_a;
  logic [glu_pkg::OPND_W-1:0] mag_b;

  assign opa   = in_tdata[31:0];
  assign opb   = in_tdata[63:32];
  assign mag_a = opa[31] ? (32'd0 - opa) : opa;
  assign mag_b = opb[31] ? (32'd0 - opb) : opb;

  assign in_tready = !qstat.full;
  assign push      = in_tvalid && !qstat.full;

  always_comb begin
    job.mag_a = mag_a;
    job.mag_b = mag_b;
    job.neg   = opa[31] ^ opb[31];
    if (in_tuser == glu_pkg::FUNC_GCD) begin
      job.kind = glu_pkg::KIND_GCD;
    end else if (mag_a == 32'd0 || mag_b == 32'd0) begin
      job.kind = glu_pkg::KIND_ERR;
    end else begin
      job.kind = glu_pkg::KIND_LCM;
    end
  end

endmodule

/* hw/rtl/glu_queue.sv */
// ----------------------------------------------------------------------------
// glu_queue
// Short job queue between front and back end so that each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module glu_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  glu_pkg::glu_job_t        job_in,
  input  logic                     pop,
  output glu_pkg::glu_job_t        job_out,
  output glu_pkg::glu_qstat_t      qstat
);

  glu_pkg::glu_job_t                mem_r [glu_pkg::QDEPTH];
  logic [glu_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [glu_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [glu_pkg::QCNT_W-1:0]       cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign qstat.full  = (cnt_r == glu_pkg::QCNT_W'(glu_pkg::QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign job_out     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/glu_back.sv */
// ----------------------------------------------------------------------------
// glu_back
// Execution engine: binary gcd one step per cycle, restoring division of
// the first magnitude by the gcd, one 32x32 multiply, sign fix-up, and the
// output register.
// ----------------------------------------------------------------------------
module glu_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  glu_pkg::glu_qstat_t      qstat,
  input  glu_pkg::glu_job_t        job,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [63:0]              out_tdata,
  output logic                     out_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_NEG  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                  state_r;
  logic [1:0]                  kind_r;
  logic                        neg_r;
  logic [glu_pkg::OPND_W-1:0]  ma_r;
  logic [glu_pkg::OPND_W-1:0]  mb_r;
  logic [glu_pkg::OPND_W-1:0]  ga_r;
  logic [glu_pkg::OPND_W-1:0]  gb_r;
  logic [4:0]                  gk_r;
  logic [glu_pkg::OPND_W-1:0]  gcd_r;
  logic [glu_pkg::OPND_W-1:0]  rem_r;
  logic [glu_pkg::OPND_W-1:0]  dvd_r;
  logic [4:0]                  cnt_r;
  logic [glu_pkg::VALUE_W-1:0] res_r;
  logic                        err_r;
  logic                        out_tvalid_r;
  logic [glu_pkg::VALUE_W-1:0] out_tdata_r;
  logic                        out_tuser_r;

  logic [glu_pkg::OPND_W-1:0]  g_w;
  logic [glu_pkg::OPND_W:0]    rem_sh_w;
  logic                        qbit_w;
  logic [glu_pkg::VALUE_W-1:0] prod_w;

  assign pop        = (state_r == S_IDLE) && !qstat.empty;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign g_w      = (ga_r | gb_r) << gk_r;
  assign rem_sh_w = {rem_r, dvd_r[31]};
  assign qbit_w   = (rem_sh_w >= {1'b0, gcd_r});
  assign prod_w   = dvd_r * mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!qstat.empty) begin
            kind_r <= job.kind;
            neg_r  <= job.neg;
            ma_r   <= job.mag_a;
            mb_r   <= job.mag_b;
            gk_r   <= '0;
            if (job.kind == glu_pkg::KIND_ERR) begin
              res_r   <= '0;
              err_r   <= 1'b1;
              state_r <= S_FIN;
            end else begin
              if (job.mag_a == 32'd0 && job.mag_b == 32'd0) begin
                ga_r <= 32'd1;
                gb_r <= 32'd0;
              end else begin
                ga_r <= job.mag_a;
                gb_r <= job.mag_b;
              end
              state_r <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (ga_r == 32'd0 || gb_r == 32'd0) begin
            gcd_r <= g_w;
            err_r <= 1'b0;
            if (kind_r == glu_pkg::KIND_GCD) begin
              res_r   <= {32'd0, g_w};
              state_r <= S_FIN;
            end else begin
              rem_r   <= '0;
              dvd_r   <= ma_r;
              cnt_r   <= '0;
              state_r <= S_DIV;
            end
          end else if (!ga_r[0] && !gb_r[0]) begin
            ga_r <= ga_r >> 1;
            gb_r <= gb_r >> 1;
            gk_r <= gk_r + 1'b1;
          end else if (!ga_r[0]) begin
            ga_r <= ga_r >> 1;
          end else if (!gb_r[0]) begin
            gb_r <= gb_r >> 1;
          end else if (ga_r >= gb_r) begin
            ga_r <= (ga_r - gb_r) >> 1;
          end else begin
            gb_r <= (gb_r - ga_r) >> 1;
          end
        end
        S_DIV: begin
          if (qbit_w) begin
            rem_r <= rem_sh_w[31:0] - gcd_r;
          end else begin
            rem_r <= rem_sh_w[31:0];
          end
          dvd_r <= {dvd_r[30:0], qbit_w};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          res_r   <= prod_w;
          state_r <= S_NEG;
        end
        S_NEG: begin
          if (neg_r) begin
            res_r <= 64'd0 - res_r;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= res_r;
            out_tuser_r  <= err_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/gcd_lcm_unit_top.sv */
// ----------------------------------------------------------------------------
// gcd_lcm_unit_top
// Greatest common divisor or signed least common multiple of two signed
// 32-bit operands.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries both operands in in_tdata and the operation in
// in_tuser (0 gcd, 1 lcm). Each input beat gives exactly one output beat,
// in order, with the 64-bit result in out_tdata and the error flag in
// out_tuser. The error flag is set, with a zero result, when lcm is asked
// with a zero operand.
// The job queue holds up to two jobs, so input beats are taken while the
// engine is busy or a result waits at the output. The engine works on one
// job at a time: a binary gcd step per cycle, then for lcm a restoring
// division of the first magnitude by the gcd, one multiply and a sign
// fix-up step.
// When the receiver holds out_tready low, the result stays in the output
// register, the engine waits, and in_tready falls once the queue is full.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic        in_tuser,   // func [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // value [63:0]
  output logic        out_tuser   // error [0]
);

  glu_pkg::glu_qstat_t qstat;
  glu_pkg::glu_job_t   job_in;
  glu_pkg::glu_job_t   job_out;
  logic                push;
  logic                pop;

  glu_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .qstat     (qstat),
    .push      (push),
    .job       (job_in)
  );

  glu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .qstat   (qstat)
  );

  glu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .job        (job_out),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("error beat with nonzero value");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata != 64'd0)
    else $error("result value is zero without error");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> qstat.full && !qstat.empty)
    else $error("input stalled while queue has room");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("engine took a job from an empty queue");
`endif

endmodule

/* tb/tb_gcd_lcm_unit_top.sv */
// ----------------------------------------------------------------------------
// tb_gcd_lcm_unit_top
// Self-checking bench for the gcd/lcm unit. A queue of operand pairs feeds a
// stream driver. Each accepted input beat is run through a behavioral gcd/lcm
// calculator, and the monitor compares every output beat with the oldest
// predicted result. The run steps through phases of sender gaps and receiver
// stalls, and drains the unit completely at the start of each phase.
// ----------------------------------------------------------------------------
module tb_gcd_lcm_unit_top;

  localparam int unsigned RANDOM_BEATS = 1926;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned TAIL_CYCLES  = 150;
  localparam int unsigned MAX_CYCLES   = 1000000;
  localparam logic [31:0] OPND_MIN     = 32'h8000_0000;
  localparam logic [31:0] OPND_MAX     = 32'h7fff_ffff;

  typedef struct {
    logic        func;
    logic [31:0] opnd_a;
    logic [31:0] opnd_b;
    int unsigned gap_pct;
    int unsigned stall_pct;
    logic        drain;
  } operand_beat_t;

  typedef struct {
    logic [glu_pkg::VALUE_W-1:0] value;
    logic                        error;
  } gcd_lcm_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  operand_beat_t   operand_beats[$];
  gcd_lcm_result_t expected_results[$];

  int unsigned stall_pct     = 0;
  int unsigned check_fails   = 0;
  int unsigned results_seen  = 0;
  int unsigned gcd_beats     = 0;
  int unsigned lcm_beats     = 0;
  int unsigned error_results = 0;

  gcd_lcm_unit_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    if (x == 32'd0 && y == 32'd0) begin
      return 32'd1;
    end
    while (x != 32'd0) begin
      r = y % x;
      y = x;
      x = r;
    end
    return y;
  endfunction

  function automatic gcd_lcm_result_t predict_gcd_lcm(logic func, logic [31:0] a,
                                                      logic [31:0] b);
    logic [31:0]     mag_a;
    logic [31:0]     mag_b;
    logic [63:0]     mag;
    gcd_lcm_result_t res;
    mag_a = a[31] ? 32'd0 - a : a;
    mag_b = b[31] ? 32'd0 - b : b;
    res.error = 1'b0;
    if (func == glu_pkg::FUNC_GCD) begin
      res.value = {32'd0, euclid_gcd(mag_a, mag_b)};
    end else if (mag_a == 32'd0 || mag_b == 32'd0) begin
      res.value = '0;
      res.error = 1'b1;
    end else begin
      mag = ({32'd0, mag_a} * {32'd0, mag_b}) / {32'd0, euclid_gcd(mag_a, mag_b)};
      if (a[31] != b[31]) begin
        mag = 64'd0 - mag;
      end
      res.value = mag;
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(7))
      0: v = 32'd0;
      1: begin
        case ($urandom_range(3))
          0: v = OPND_MIN;
          1: v = OPND_MAX;
          2: v = 32'hffff_ffff;
          default: v = 32'd1;
        endcase
      end
      2: begin
        v = 32'd1 << $urandom_range(31);
        if ($urandom_range(1) == 1) begin
          v = 32'd0 - v;
        end
      end
      3: v = 32'($urandom_range(200)) - 32'd100;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Stream driver: a new beat may load only after the previous one is taken.
  always @(posedge clk) begin : drive_proc
    operand_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_gcd_lcm(in_tuser, in_tdata[31:0],
                                                   in_tdata[63:32]));
        if (in_tuser == glu_pkg::FUNC_GCD) begin
          gcd_beats++;
        end else begin
          lcm_beats++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (operand_beats.size() > 0 &&
            (!operand_beats[0].drain || expected_results.size() == 0) &&
            $urandom_range(99) >= operand_beats[0].gap_pct) begin
          nb = operand_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nb.opnd_b, nb.opnd_a};
          in_tuser  <= nb.func;
          stall_pct <= nb.stall_pct;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random backpressure.
  always @(posedge clk) begin : monitor_proc
    gcd_lcm_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser) begin
          error_results++;
        end
        if (expected_results.size() == 0) begin
          check_fails++;
          if (check_fails <= 10) begin
            $display("result beat %0d arrived with nothing expected: value %h error %b",
                     results_seen, out_tdata, out_tuser);
          end
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tdata !== exp_res.value || out_tuser !== exp_res.error) begin
            check_fails++;
            if (check_fails <= 10) begin
              $display("result beat %0d mismatch: value exp %h got %h, error exp %b got %b",
                       results_seen, exp_res.value, out_tdata, exp_res.error, out_tuser);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus_proc
    logic [31:0]   corner_a[12];
    logic [31:0]   corner_b[12];
    operand_beat_t nb;
    logic [31:0]   g;
    int unsigned   phase;
    corner_a = '{32'd0, 32'd0, OPND_MIN, OPND_MIN, OPND_MAX, OPND_MAX,
                 32'hffff_ffff, 32'd1, 32'd0, 32'hffff_fff9, 32'd12, OPND_MAX};
    corner_b = '{32'd0, OPND_MIN, 32'd0, OPND_MIN, OPND_MAX, OPND_MIN,
                 32'hffff_ffff, 32'hffff_ffff, 32'd5, 32'd0, 32'hffff_ffee,
                 32'h7fff_fffe};
    for (int i = 0; i < 12; i++) begin
      for (int f = 0; f < 2; f++) begin
        nb.func      = (f == 0) ? glu_pkg::FUNC_GCD : glu_pkg::FUNC_LCM;
        nb.opnd_a    = corner_a[i];
        nb.opnd_b    = corner_b[i];
        nb.gap_pct   = 0;
        nb.stall_pct = 0;
        nb.drain     = 1'b0;
        operand_beats.push_back(nb);
      end
    end
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      phase   = k * NUM_PHASES / RANDOM_BEATS;
      nb.func = $urandom_range(1) ? glu_pkg::FUNC_LCM : glu_pkg::FUNC_GCD;
      if ($urandom_range(3) == 0) begin
        g = $urandom_range(65535, 1) >> $urandom_range(15);
        nb.opnd_a = g * $urandom_range(32767, 1);
        nb.opnd_b = g * $urandom_range(32767, 1);
        if ($urandom_range(1) == 1) begin
          nb.opnd_a = 32'd0 - nb.opnd_a;
        end
        if ($urandom_range(1) == 1) begin
          nb.opnd_b = 32'd0 - nb.opnd_b;
        end
      end else begin
        nb.opnd_a = pick_operand();
        nb.opnd_b = pick_operand();
      end
      case (phase)
        1: begin
          nb.gap_pct   = 81;
          nb.stall_pct = 0;
        end
        2: begin
          nb.gap_pct   = 0;
          nb.stall_pct = 81;
        end
        3: begin
          nb.gap_pct   = 22;
          nb.stall_pct = 22;
        end
        default: begin
          nb.gap_pct   = 0;
          nb.stall_pct = 0;
        end
      endcase
      nb.drain = (k * NUM_PHASES % RANDOM_BEATS) < NUM_PHASES;
      operand_beats.push_back(nb);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (operand_beats.size() > 0 || in_tvalid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result beats: %0d gcd and %0d lcm requests, %0d with error set,",
             results_seen, gcd_beats, lcm_beats, error_results);
    $display("over corner operands and %0d phases of sender gaps and receiver stalls.",
             NUM_PHASES);
    if (check_fails == 0 && expected_results.size() == 0) begin
      $display("tb_gcd_lcm_unit_top: PASS");
    end else begin
      $display("tb_gcd_lcm_unit_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #(4 * MAX_CYCLES);
    $display("Run timed out with %0d results still expected.", expected_results.size());
    $display("tb_gcd_lcm_unit_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/glu_pkg.sv
hw/rtl/glu_front.sv
hw/rtl/glu_queue.sv
hw/rtl/glu_back.sv
hw/rtl/gcd_lcm_unit_top.sv
tb/tb_gcd_lcm_unit_top.sv
